FILE: rtl/gmdfs_pkg.sv
// Shared types, constants and helper functions for the grid maze path finder.
// Used by gmdfs_ctrl, gmdfs_dp, the top level and the checker; depends on nothing else.
`default_nettype none

package gmdfs_pkg;

    // Default grid parameters and fixed field widths.
    localparam int GRID_ROWS_DEF = 8;
    localparam int GRID_COLS_DEF = 8;
    localparam int DIM_CAP       = 8;
    localparam int COORD_W       = 3;
    localparam int DIM_W         = 4;
    localparam int DIR_W         = 2;
    localparam int FROM_W        = 3;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 4;
    localparam int TDATA_W       = 8;
    localparam int TOTAL_W       = 2 * DIM_W;

    // Reciprocals for dividing a load position by the column count.
    // quotient = (pos * RECIP_TABLE[cols - 1]) >> RECIP_SHIFT, exact for pos < 64.
    localparam int RECIP_SHIFT = 10;
    localparam int RECIP_W     = 11;
    localparam int RECIP_IDX_W = $clog2(DIM_CAP);
    typedef logic [RECIP_W-1:0] recip_t;
    localparam recip_t RECIP_TABLE [DIM_CAP] = '{
        11'd1024, 11'd512, 11'd342, 11'd256, 11'd205, 11'd171, 11'd147, 11'd128
    };

    // Direction codes in the order they are tried.
    typedef enum logic [DIR_W-1:0] {
        DIR_DOWN  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    // Direction counter value once all four directions were tried.
    localparam logic [FROM_W-1:0] FROM_DONE = 3'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_ROWS = 3'd0,
        REG_GRID_COLS = 3'd1,
        REG_START_ROW = 3'd2,
        REG_START_COL = 3'd3,
        REG_GOAL_ROW  = 3'd4,
        REG_GOAL_COL  = 3'd5
    } cfg_reg_t;

    // One search stack entry: a cell and the direction being explored from it.
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        dir_t               dir;
    } stack_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_accept;
        logic start_init;
        logic found_write;
        logic dir_skip;
        logic probe_rd;
        logic push;
        logic pop;
        logic restore;
        logic out_rd;
        logic out_load_path;
        logic out_inc;
        logic out_load_nf;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_busy;
        logic start_ok;
        logic at_goal;
        logic from_done;
        logic nbr_inside;
        logic probe_free;
        logic depth_one;
        logic out_last;
        logic out_free;
    } dp_status_t;

    // Grid size in use: zero acts as one, anything above the cap acts as the cap.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] result;
        if (value == '0)
        begin
            result = DIM_W'(1);
        end
        else if (value > cap)
        begin
            result = cap;
        end
        else
        begin
            result = value;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gmdfs_dp.sv
// Datapath of the grid maze path finder: configuration registers, cell load
// pipeline, wall/mark/stack memories, search registers and the output register.
// Depends on gmdfs_pkg.
`default_nettype none

module gmdfs_dp #(
    parameter int GRID_ROWS = gmdfs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gmdfs_pkg::GRID_COLS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wen,
    input  wire logic [gmdfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gmdfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                 cell_blocked,
    input  wire gmdfs_pkg::ctrl_cmd_t                 cmd,
    output gmdfs_pkg::dp_status_t                     status,
    input  wire logic                                 m_ready,
    output logic                                      m_valid,
    output logic                                      m_found,
    output logic [gmdfs_pkg::COORD_W-1:0]             m_row,
    output logic [gmdfs_pkg::COORD_W-1:0]             m_col,
    output logic                                      m_last
);

    localparam int COORD_W  = gmdfs_pkg::COORD_W;
    localparam int DIM_W    = gmdfs_pkg::DIM_W;
    localparam int TOTAL_W  = gmdfs_pkg::TOTAL_W;
    localparam int ROWS_CAP = (GRID_ROWS < gmdfs_pkg::DIM_CAP) ? GRID_ROWS : gmdfs_pkg::DIM_CAP;
    localparam int COLS_CAP = (GRID_COLS < gmdfs_pkg::DIM_CAP) ? GRID_COLS : gmdfs_pkg::DIM_CAP;
    localparam int CELLS    = ROWS_CAP * COLS_CAP;
    localparam int CELL_W   = $clog2(CELLS);
    localparam int DEPTH_W  = $clog2(CELLS + 1);
    localparam int PROD_W   = CELL_W + gmdfs_pkg::RECIP_W;

    localparam logic [DIM_W-1:0] ROWS_CAP_V = DIM_W'(ROWS_CAP);
    localparam logic [DIM_W-1:0] COLS_CAP_V = DIM_W'(COLS_CAP);

    // Linear store address of a cell.
    function automatic logic [CELL_W-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                     input logic [COORD_W-1:0] col);
        return CELL_W'(int'(row) * COLS_CAP + int'(col));
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0]   grid_rows_reg;
    logic [DIM_W-1:0]   grid_cols_reg;
    logic [COORD_W-1:0] start_row_reg;
    logic [COORD_W-1:0] start_col_reg;
    logic [COORD_W-1:0] goal_row_reg;
    logic [COORD_W-1:0] goal_col_reg;

    // Load pipeline.
    logic [CELL_W-1:0]  load_pos_reg;
    logic               ld1_vld_reg;
    logic [CELL_W-1:0]  ld1_pos_reg;
    logic               ld1_wall_reg;
    logic               ld2_vld_reg;
    logic [CELL_W-1:0]  ld2_pos_reg;
    logic [COORD_W-1:0] ld2_row_reg;
    logic               ld2_wall_reg;
    logic               ld3_vld_reg;
    logic [COORD_W-1:0] ld3_row_reg;
    logic [COORD_W-1:0] ld3_col_reg;
    logic               ld3_wall_reg;

    // Memories and their valid bits.
    logic                          wall_mem [CELLS];
    logic                          mark_mem [CELLS];
    gmdfs_pkg::stack_entry_t       stack_mem [CELLS];
    logic [CELLS-1:0]              wall_vld_reg;
    logic [CELLS-1:0]              mark_vld_reg;
    logic                          wall_rd_reg;
    logic                          wall_vld_rd_reg;
    logic                          mark_rd_reg;
    logic                          mark_vld_rd_reg;
    gmdfs_pkg::stack_entry_t       stk_rd_reg;

    // Search registers.
    logic [COORD_W-1:0]            cur_row_reg;
    logic [COORD_W-1:0]            cur_col_reg;
    logic [gmdfs_pkg::FROM_W-1:0]  from_reg;
    logic [DEPTH_W-1:0]            depth_reg;
    logic [CELL_W-1:0]             out_idx_reg;

    // Output register.
    logic                          m_valid_reg;
    logic                          m_found_reg;
    logic [COORD_W-1:0]            m_row_reg;
    logic [COORD_W-1:0]            m_col_reg;
    logic                          m_last_reg;

    // Combinational helpers.
    logic [DIM_W-1:0]              nr;
    logic [DIM_W-1:0]              nc;
    logic [DIM_W-1:0]              nc_m1;
    logic [TOTAL_W-1:0]            total;
    logic [CELL_W-1:0]             pos_eff;
    logic [TOTAL_W-1:0]            pos_inc;
    logic [CELL_W-1:0]             pos_next;
    logic [PROD_W-1:0]             ld_prod;
    logic [TOTAL_W-1:0]            row_base;
    logic [CELL_W-1:0]             ld_idx;
    logic [COORD_W-1:0]            nbr_row;
    logic [COORD_W-1:0]            nbr_col;
    logic                          nbr_inside;
    logic [CELL_W-1:0]             nbr_idx;
    logic [CELL_W-1:0]             cur_idx;
    logic [DEPTH_W-1:0]            depth_m1;
    logic [DEPTH_W-1:0]            depth_m2;
    logic                          mark_we;
    logic [CELL_W-1:0]             mark_waddr;
    logic                          mark_wdata;
    logic                          stk_we;
    gmdfs_pkg::stack_entry_t       stk_wdata;
    logic                          stk_re;
    logic [CELL_W-1:0]             stk_raddr;
    logic                          out_free;

    // Grid size in use and load position arithmetic.
    assign nr       = gmdfs_pkg::clamp_dim(grid_rows_reg, ROWS_CAP_V);
    assign nc       = gmdfs_pkg::clamp_dim(grid_cols_reg, COLS_CAP_V);
    assign nc_m1    = nc - DIM_W'(1);
    assign total    = TOTAL_W'(nr) * TOTAL_W'(nc);
    assign pos_eff  = (TOTAL_W'(load_pos_reg) >= total) ? '0 : load_pos_reg;
    assign pos_inc  = TOTAL_W'(pos_eff) + TOTAL_W'(1);
    assign pos_next = (pos_inc >= total) ? '0 : pos_inc[CELL_W-1:0];

    // Row of a load position by reciprocal multiplication, then the column remainder.
    assign ld_prod  = PROD_W'(ld1_pos_reg)
                    * PROD_W'(gmdfs_pkg::RECIP_TABLE[nc_m1[gmdfs_pkg::RECIP_IDX_W-1:0]]);
    assign row_base = TOTAL_W'(ld2_row_reg) * TOTAL_W'(nc);
    assign ld_idx   = cell_index(ld3_row_reg, ld3_col_reg);

    // Neighbor of the current cell in the direction under trial.
    always_comb
    begin
        nbr_row    = cur_row_reg;
        nbr_col    = cur_col_reg;
        nbr_inside = 1'b0;
        case (gmdfs_pkg::dir_t'(from_reg[gmdfs_pkg::DIR_W-1:0]))
            gmdfs_pkg::DIR_DOWN:
            begin
                nbr_row    = cur_row_reg + COORD_W'(1);
                nbr_inside = (DIM_W'(cur_row_reg) + DIM_W'(1)) < nr;
            end
            gmdfs_pkg::DIR_RIGHT:
            begin
                nbr_col    = cur_col_reg + COORD_W'(1);
                nbr_inside = (DIM_W'(cur_col_reg) + DIM_W'(1)) < nc;
            end
            gmdfs_pkg::DIR_UP:
            begin
                nbr_row    = cur_row_reg - COORD_W'(1);
                nbr_inside = (cur_row_reg != '0);
            end
            gmdfs_pkg::DIR_LEFT:
            begin
                nbr_col    = cur_col_reg - COORD_W'(1);
                nbr_inside = (cur_col_reg != '0);
            end
            default:
            begin
                nbr_inside = 1'b0;
            end
        endcase
    end

    assign nbr_idx  = cell_index(nbr_row, nbr_col);
    assign cur_idx  = cell_index(cur_row_reg, cur_col_reg);
    assign depth_m1 = depth_reg - DEPTH_W'(1);
    assign depth_m2 = depth_reg - DEPTH_W'(2);

    // Mark store write port: set on start and push, clear on backtrack.
    always_comb
    begin
        mark_we    = cmd.start_init | cmd.push | cmd.pop;
        mark_wdata = ~cmd.pop;
        if (cmd.start_init)
        begin
            mark_waddr = cell_index(start_row_reg, start_col_reg);
        end
        else if (cmd.push)
        begin
            mark_waddr = nbr_idx;
        end
        else
        begin
            mark_waddr = cur_idx;
        end
    end

    // Stack ports: the top entry gets its direction on push, or is closed on the goal.
    assign stk_we        = cmd.push | cmd.found_write;
    assign stk_wdata.row = cur_row_reg;
    assign stk_wdata.col = cur_col_reg;
    assign stk_wdata.dir = cmd.push ? gmdfs_pkg::dir_t'(from_reg[gmdfs_pkg::DIR_W-1:0])
                                    : gmdfs_pkg::DIR_DOWN;
    assign stk_re        = (cmd.pop & (depth_reg != DEPTH_W'(1))) | cmd.out_rd;
    assign stk_raddr     = cmd.out_rd ? out_idx_reg : depth_m2[CELL_W-1:0];

    assign out_free = ~m_valid_reg | m_ready;

    // Status toward the controller.
    assign status.load_busy  = ld1_vld_reg | ld2_vld_reg | ld3_vld_reg;
    assign status.start_ok   = (DIM_W'(start_row_reg) < nr) && (DIM_W'(start_col_reg) < nc)
                            && (DIM_W'(goal_row_reg) < nr) && (DIM_W'(goal_col_reg) < nc);
    assign status.at_goal    = (cur_row_reg == goal_row_reg) && (cur_col_reg == goal_col_reg);
    assign status.from_done  = (from_reg == gmdfs_pkg::FROM_DONE);
    assign status.nbr_inside = nbr_inside;
    assign status.probe_free = ~(wall_rd_reg & wall_vld_rd_reg)
                             & ~(mark_rd_reg & mark_vld_rd_reg);
    assign status.depth_one  = (depth_reg == DEPTH_W'(1));
    assign status.out_last   = ((DEPTH_W'(out_idx_reg) + DEPTH_W'(1)) == depth_reg);
    assign status.out_free   = out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= DIM_W'(gmdfs_pkg::DIM_CAP);
            grid_cols_reg <= DIM_W'(gmdfs_pkg::DIM_CAP);
            start_row_reg <= '0;
            start_col_reg <= '0;
            goal_row_reg  <= '0;
            goal_col_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (gmdfs_pkg::cfg_reg_t'(cfg_index))
                gmdfs_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                gmdfs_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data;
                gmdfs_pkg::REG_START_ROW: start_row_reg <= cfg_data[COORD_W-1:0];
                gmdfs_pkg::REG_START_COL: start_col_reg <= cfg_data[COORD_W-1:0];
                gmdfs_pkg::REG_GOAL_ROW:  goal_row_reg  <= cfg_data[COORD_W-1:0];
                gmdfs_pkg::REG_GOAL_COL:  goal_col_reg  <= cfg_data[COORD_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Control state: load position, pipeline valids, store valid bits, search state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg    <= '0;
            ld1_vld_reg     <= 1'b0;
            ld2_vld_reg     <= 1'b0;
            ld3_vld_reg     <= 1'b0;
            wall_vld_reg    <= '0;
            mark_vld_reg    <= '0;
            wall_vld_rd_reg <= 1'b0;
            mark_vld_rd_reg <= 1'b0;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            from_reg        <= '0;
            depth_reg       <= '0;
            out_idx_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            ld1_vld_reg <= cmd.load_accept;
            ld2_vld_reg <= ld1_vld_reg;
            ld3_vld_reg <= ld2_vld_reg;

            if (cmd.load_accept)
            begin
                load_pos_reg <= pos_next;
            end
            else if (cmd.finish)
            begin
                load_pos_reg <= '0;
            end

            if (ld3_vld_reg)
            begin
                wall_vld_reg[ld_idx] <= 1'b1;
            end

            if (cmd.finish)
            begin
                mark_vld_reg <= '0;
            end
            else if (mark_we)
            begin
                mark_vld_reg[mark_waddr] <= 1'b1;
            end

            if (cmd.probe_rd)
            begin
                wall_vld_rd_reg <= wall_vld_reg[nbr_idx];
                mark_vld_rd_reg <= mark_vld_reg[nbr_idx];
            end

            // Current cell, direction counter and stack depth.
            if (cmd.start_init)
            begin
                cur_row_reg <= start_row_reg;
                cur_col_reg <= start_col_reg;
                from_reg    <= '0;
                depth_reg   <= DEPTH_W'(1);
            end
            else if (cmd.push)
            begin
                cur_row_reg <= nbr_row;
                cur_col_reg <= nbr_col;
                from_reg    <= '0;
                depth_reg   <= depth_reg + DEPTH_W'(1);
            end
            else if (cmd.dir_skip)
            begin
                from_reg <= from_reg + gmdfs_pkg::FROM_W'(1);
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_m1;
            end
            else if (cmd.restore)
            begin
                cur_row_reg <= stk_rd_reg.row;
                cur_col_reg <= stk_rd_reg.col;
                from_reg    <= gmdfs_pkg::FROM_W'(stk_rd_reg.dir) + gmdfs_pkg::FROM_W'(1);
            end
            else if (cmd.finish)
            begin
                depth_reg <= '0;
            end

            if (cmd.found_write)
            begin
                out_idx_reg <= '0;
            end
            else if (cmd.out_inc)
            begin
                out_idx_reg <= out_idx_reg + CELL_W'(1);
            end

            if (cmd.out_load_path || cmd.out_load_nf)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load pipeline payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_accept)
        begin
            ld1_pos_reg  <= pos_eff;
            ld1_wall_reg <= cell_blocked;
        end
        ld2_pos_reg  <= ld1_pos_reg;
        ld2_row_reg  <= ld_prod[gmdfs_pkg::RECIP_SHIFT +: COORD_W];
        ld2_wall_reg <= ld1_wall_reg;
        ld3_row_reg  <= ld2_row_reg;
        ld3_col_reg  <= COORD_W'(TOTAL_W'(ld2_pos_reg) - row_base);
        ld3_wall_reg <= ld2_wall_reg;
    end

    // Wall store.
    always_ff @(posedge clk)
    begin
        if (ld3_vld_reg)
        begin
            wall_mem[ld_idx] <= ld3_wall_reg;
        end
        if (cmd.probe_rd)
        begin
            wall_rd_reg <= wall_mem[nbr_idx];
        end
    end

    // Path mark store.
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (cmd.probe_rd)
        begin
            mark_rd_reg <= mark_mem[nbr_idx];
        end
    end

    // Search stack.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[depth_m1[CELL_W-1:0]] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stack_mem[stk_raddr];
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_path)
        begin
            m_found_reg <= 1'b1;
            m_row_reg   <= stk_rd_reg.row;
            m_col_reg   <= stk_rd_reg.col;
            m_last_reg  <= status.out_last;
        end
        else if (cmd.out_load_nf)
        begin
            m_found_reg <= 1'b0;
            m_row_reg   <= '0;
            m_col_reg   <= '0;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;
    assign m_row   = m_row_reg;
    assign m_col   = m_col_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

FILE: rtl/gmdfs_ctrl.sv
// Controller state machine of the grid maze path finder: cell intake, the
// depth-first search sequence and the result sequence. Depends on gmdfs_pkg.
`default_nettype none

module gmdfs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tlast,
    output logic                       s_tready,
    input  wire gmdfs_pkg::dp_status_t status,
    output gmdfs_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_START,
        ST_CHECK,
        ST_TRY,
        ST_PROBE,
        ST_POP,
        ST_RESTORE,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_NOT_FOUND,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept   = s_tvalid && (state_reg == ST_LOAD);
    assign s_tready = (state_reg == ST_LOAD);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.load_accept = accept;
                if (accept && s_tlast)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.load_busy)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.start_ok)
                begin
                    cmd.start_init = 1'b1;
                    state_next     = ST_CHECK;
                end
                else
                begin
                    state_next = ST_NOT_FOUND;
                end
            end
            ST_CHECK:
            begin
                if (status.at_goal)
                begin
                    cmd.found_write = 1'b1;
                    state_next      = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_TRY;
                end
            end
            ST_TRY:
            begin
                if (status.from_done)
                begin
                    state_next = ST_POP;
                end
                else if (!status.nbr_inside)
                begin
                    cmd.dir_skip = 1'b1;
                end
                else
                begin
                    cmd.probe_rd = 1'b1;
                    state_next   = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (status.probe_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.dir_skip = 1'b1;
                    state_next   = ST_TRY;
                end
            end
            ST_POP:
            begin
                cmd.pop = 1'b1;
                if (status.depth_one)
                begin
                    state_next = ST_NOT_FOUND;
                end
                else
                begin
                    state_next = ST_RESTORE;
                end
            end
            ST_RESTORE:
            begin
                cmd.restore = 1'b1;
                state_next  = ST_TRY;
            end
            ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load_path = 1'b1;
                    if (status.out_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.out_inc = 1'b1;
                        state_next  = ST_OUT_RD;
                    end
                end
            end
            ST_NOT_FOUND:
            begin
                if (status.out_free)
                begin
                    cmd.out_load_nf = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/grid_maze_dfs_path_finder.sv
// Throughput: cells are taken one beat per cycle while s_tready is high. The tlast beat
// stalls intake through load pipeline drain, the start state and the search: try reads a
// neighbor (skips one outside the grid), probe judges it, check follows a step forward, pop
// and restore a step back. Each path beat is read from the stack, then loaded; finish closes.
// Reset (rst_n, asynchronous): 8x8 grid, start and goal at 0/0, all cells free.
// Depends on gmdfs_pkg, gmdfs_ctrl and gmdfs_dp.
`default_nettype none

module grid_maze_dfs_path_finder #(
    parameter int GRID_ROWS = gmdfs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gmdfs_pkg::GRID_COLS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wen,
    input  wire logic [gmdfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gmdfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [gmdfs_pkg::TDATA_W-1:0]      s_tdata,   // [0] cell_blocked
    input  wire logic                               s_tlast,   // last_cell
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [gmdfs_pkg::TDATA_W-1:0]           m_tdata,   // [2:0] path_row, [5:3] path_col
    output logic                                    m_tuser,   // [0] found
    output logic                                    m_tlast    // last_step
);

    localparam int COORD_W = gmdfs_pkg::COORD_W;
    localparam int PAD_W   = gmdfs_pkg::TDATA_W - 2 * COORD_W;

    gmdfs_pkg::ctrl_cmd_t  cmd;
    gmdfs_pkg::dp_status_t status;
    logic [COORD_W-1:0]    m_row;
    logic [COORD_W-1:0]    m_col;

    gmdfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gmdfs_dp #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_blocked (s_tdata[0]),
        .cmd          (cmd),
        .status       (status),
        .m_ready      (m_tready),
        .m_valid      (m_tvalid),
        .m_found      (m_tuser),
        .m_row        (m_row),
        .m_col        (m_col),
        .m_last       (m_tlast)
    );

    // Output beat packing, first field in the lowest bits.
    assign m_tdata = {PAD_W'(0), m_col, m_row};

endmodule

`default_nettype wire

FILE: rtl/gmdfs_checker.sv
// Port-level checks for the grid maze path finder, bound to the top level.
// Depends on gmdfs_pkg and grid_maze_dfs_path_finder.
`default_nettype none

module gmdfs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [gmdfs_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          m_tlast
);

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // A not-found beat closes its run.
    a_nf_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("not-found beat without tlast");

    // A not-found beat carries zero coordinates.
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata == '0))
        else $error("not-found beat with nonzero coordinates");

    // The final cell starts the search, so intake stops on the next cycle.
    a_search_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("intake kept running after the final cell");

endmodule

bind grid_maze_dfs_path_finder gmdfs_checker u_gmdfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
